/* design/stc_pkg.sv */
package stc_pkg;

   // Field and register widths
   localparam int FREQ_BITS     = 20;
   localparam int STEP_BITS     = 10;
   localparam int CHAN_BITS     = 3;
   localparam int JUMP_BITS     = 16;
   localparam int CSR_DATA_BITS = 20;
   localparam int CSR_IDX_BITS  = 2;
   localparam int STATUS_BITS   = 2;

   // Signed working width for frequency sums and the x10 tune test
   localparam int ARITH_BITS = FREQ_BITS + 5;
   // Width for the slope comparison (delta x 1000)
   localparam int SLOPE_BITS = ARITH_BITS + 10;
   // Secant dividend and the bit-serial divider
   localparam int PROD_BITS    = FREQ_BITS + STEP_BITS;
   localparam int DIV_STEPS    = PROD_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

   // Frequency constants in 1/256 Hz
   localparam int ONE_HZ      = 256;
   localparam int TWO_HZ      = 512;
   localparam int FIVE_HZ     = 1280;
   localparam int HALF_HZ     = 128;
   localparam int TUNE_SCALE  = 10;
   localparam int TUNE_MARGIN = 256;    // 0.1 Hz with both sides x10
   localparam int SLOPE_SCALE = 1000;   // 0.001 Hz per step

   // Fine phase step sizes
   localparam int FINE_STEP_XL = 100;
   localparam int FINE_STEP_L  = 50;
   localparam int FINE_STEP_M  = 25;
   localparam int FINE_STEP_S  = 10;

   // Register reset values
   localparam logic [FREQ_BITS-1:0] TARGET_RESET = FREQ_BITS'(28160);
   localparam logic [STEP_BITS-1:0] FIRST_RESET  = STEP_BITS'(200);
   localparam logic [STEP_BITS-1:0] MAX_RESET    = STEP_BITS'(500);
   localparam logic [JUMP_BITS-1:0] JUMP_RESET   = JUMP_BITS'(3840);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PROBE,
      PH_COARSE,
      PH_FINE
   } phase_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_STEP,
      ST_RESAMPLE,
      ST_TUNED,
      ST_IGNORED
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_TARGET_FREQ,
      REG_FIRST_STEP,
      REG_MAX_STEP,
      REG_JUMP_WINDOW
   } reg_index_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic div_start;
      logic div_step;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } dp_status_type;

endpackage

/* design/stc_if.sv */
// Input item channel
interface stc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [stc_pkg::CHAN_BITS-1:0]  string_sel;
   logic [stc_pkg::FREQ_BITS-1:0]  measured_freq;

   modport source (output valid, mode, string_sel, measured_freq, input ready);
   modport sink   (input valid, mode, string_sel, measured_freq, output ready);
endinterface

// Result item channel
interface stc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [stc_pkg::STATUS_BITS-1:0]  status;
   logic [stc_pkg::STEP_BITS-1:0]    step_count;
   logic [stc_pkg::CHAN_BITS-1:0]    motor_channel;

   modport source (output valid, status, step_count, motor_channel, input ready);
   modport sink   (input valid, status, step_count, motor_channel, output ready);
endinterface

// Register write channel
interface stc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [stc_pkg::CSR_IDX_BITS-1:0]   index;
   logic [stc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/stc_ctrl.sv */
module stc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  stc_pkg::dp_status_type sts,
   output stc_pkg::cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_WAIT,
      S_EVAL,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_WAIT);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Sequencing and commands
   always_comb begin
      state_in      = state_ff;
      cmd.load_item = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         S_WAIT: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               state_in      = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_WAIT;
            end
         end
         default: state_in = S_WAIT;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A commit never overwrites a result that is still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   // An accepted item is evaluated in the next cycle
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EVAL))
      else $error("accepted item not evaluated");

   // The divider is never stepped past its last bit
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !sts.div_done)
      else $error("divider stepped after completion");

endmodule

/* design/stc_dp.sv */
module stc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  stc_pkg::cmd_type                    cmd,
   output stc_pkg::dp_status_type              sts,
   input  logic                                csr_we,
   input  logic [stc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [stc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                req_mode,
   input  logic [stc_pkg::CHAN_BITS-1:0]       req_string_sel,
   input  logic [stc_pkg::FREQ_BITS-1:0]       req_measured_freq,
   output logic [stc_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [stc_pkg::STEP_BITS-1:0]       rsp_step_count,
   output logic [stc_pkg::CHAN_BITS-1:0]       rsp_motor_channel
);

   localparam int FB = stc_pkg::FREQ_BITS;
   localparam int SB = stc_pkg::STEP_BITS;
   localparam int AW = stc_pkg::ARITH_BITS;
   localparam int LW = stc_pkg::SLOPE_BITS;
   localparam int PB = stc_pkg::PROD_BITS;

   // Configuration registers
   logic [FB-1:0]                  target_ff;
   logic [SB-1:0]                  first_ff;
   logic [SB-1:0]                  max_ff;
   logic [stc_pkg::JUMP_BITS-1:0]  jump_ff;

   // Tuning state
   stc_pkg::phase_type             phase_ff;
   logic [FB-1:0]                  prev_freq_ff;
   logic [SB-1:0]                  last_step_ff;
   logic [stc_pkg::CHAN_BITS-1:0]  channel_ff;

   // Latched item
   logic                           mode_ff;
   logic [stc_pkg::CHAN_BITS-1:0]  sel_ff;
   logic [FB-1:0]                  freq_ff;

   // Divider
   logic [FB-1:0]                    rem_ff, rem_in;
   logic [PB-1:0]                    quo_ff, quo_in;
   logic [stc_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   // Result register
   stc_pkg::status_type            out_status_ff;
   logic [SB-1:0]                  out_step_ff;
   logic [stc_pkg::CHAN_BITS-1:0]  out_chan_ff;

   // Arithmetic
   logic signed [AW-1:0] freq_s, tgt_s, prev_s, delta_s, dist_s, num_s;
   logic signed [AW-1:0] freq_x10, tgt_x10;
   logic signed [LW-1:0] delta_x1000, step_x256;
   logic                 slope_hi, jump_bad, near_target, tune_hit, secant_trivial;
   logic [SB-1:0]        eff_max, eff_first, start_step, reuse_step, fine_step, secant_step;
   logic [PB-1:0]        product;
   logic [FB-1:0]        divisor;
   logic [FB:0]          trial;
   logic                 trial_ge;

   // Decision
   stc_pkg::status_type  dec_status;
   stc_pkg::phase_type   dec_phase;
   logic [SB-1:0]        dec_step;
   logic                 upd_prev, upd_step, upd_chan, use_div;
   logic [SB-1:0]        res_step;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= stc_pkg::TARGET_RESET;
         first_ff  <= stc_pkg::FIRST_RESET;
         max_ff    <= stc_pkg::MAX_RESET;
         jump_ff   <= stc_pkg::JUMP_RESET;
      end else if (csr_we) begin
         case (stc_pkg::reg_index_type'(csr_index))
            stc_pkg::REG_TARGET_FREQ: target_ff <= FB'(csr_data);
            stc_pkg::REG_FIRST_STEP:  first_ff  <= csr_data[SB-1:0];
            stc_pkg::REG_MAX_STEP:    max_ff    <= csr_data[SB-1:0];
            stc_pkg::REG_JUMP_WINDOW: jump_ff   <= csr_data[stc_pkg::JUMP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Item latch
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         sel_ff  <= '0;
         freq_ff <= '0;
      end else if (cmd.load_item) begin
         mode_ff <= req_mode;
         sel_ff  <= req_string_sel;
         freq_ff <= req_measured_freq;
      end
   end

   // Signed views and the tests on the reading
   always_comb begin
      freq_s   = $signed(AW'(freq_ff));
      tgt_s    = $signed(AW'(target_ff));
      prev_s   = $signed(AW'(prev_freq_ff));
      delta_s  = freq_s - prev_s;
      dist_s   = delta_s[AW-1] ? -delta_s : delta_s;
      num_s    = tgt_s - $signed(AW'(stc_pkg::ONE_HZ)) - freq_s;
      freq_x10 = freq_s * $signed(AW'(stc_pkg::TUNE_SCALE));
      tgt_x10  = tgt_s * $signed(AW'(stc_pkg::TUNE_SCALE));

      delta_x1000 = LW'(delta_s) * $signed(LW'(stc_pkg::SLOPE_SCALE));
      step_x256   = $signed(LW'(last_step_ff)) * $signed(LW'(stc_pkg::ONE_HZ));
      slope_hi    = delta_x1000 > step_x256;

      jump_bad    = dist_s > $signed(AW'(jump_ff));
      near_target = freq_s >= tgt_s - $signed(AW'(stc_pkg::TWO_HZ));
      tune_hit    = freq_x10 > tgt_x10 - $signed(AW'(stc_pkg::TUNE_MARGIN));

      secant_trivial = num_s[AW-1] || (num_s == '0) || delta_s[AW-1] || (delta_s == '0);
   end

   // Step sizes
   always_comb begin
      eff_max    = (max_ff == '0) ? SB'(1) : max_ff;
      eff_first  = (first_ff == '0) ? SB'(1) : first_ff;
      start_step = (eff_first > eff_max) ? eff_max : eff_first;

      reuse_step = (last_step_ff > eff_max) ? eff_max : last_step_ff;
      if (reuse_step == '0) begin
         reuse_step = SB'(1);
      end

      if (freq_s < tgt_s - $signed(AW'(stc_pkg::FIVE_HZ))) begin
         fine_step = SB'(stc_pkg::FINE_STEP_XL);
      end else if (freq_s < tgt_s - $signed(AW'(stc_pkg::ONE_HZ))) begin
         fine_step = SB'(stc_pkg::FINE_STEP_L);
      end else if (freq_s < tgt_s - $signed(AW'(stc_pkg::HALF_HZ))) begin
         fine_step = SB'(stc_pkg::FINE_STEP_M);
      end else if (freq_s < tgt_s) begin
         fine_step = SB'(stc_pkg::FINE_STEP_S);
      end else begin
         fine_step = '0;
      end

      // secant quotient, clamped to 1..max
      if (quo_ff == '0) begin
         secant_step = SB'(1);
      end else if (quo_ff > PB'(eff_max)) begin
         secant_step = eff_max;
      end else begin
         secant_step = quo_ff[SB-1:0];
      end
   end

   // Decision for the latched item
   always_comb begin
      dec_status = stc_pkg::ST_IGNORED;
      dec_phase  = phase_ff;
      dec_step   = '0;
      upd_prev   = 1'b0;
      upd_step   = 1'b0;
      upd_chan   = 1'b0;
      use_div    = 1'b0;
      if (!mode_ff) begin
         // start item
         upd_chan = 1'b1;
         if (freq_ff == '0) begin
            dec_phase  = stc_pkg::PH_IDLE;
            dec_status = stc_pkg::ST_RESAMPLE;
         end else begin
            upd_prev   = 1'b1;
            upd_step   = 1'b1;
            dec_step   = start_step;
            dec_phase  = stc_pkg::PH_PROBE;
            dec_status = stc_pkg::ST_STEP;
         end
      end else if (phase_ff == stc_pkg::PH_IDLE) begin
         dec_status = stc_pkg::ST_IGNORED;
      end else if (freq_ff == '0) begin
         dec_status = stc_pkg::ST_RESAMPLE;
      end else if (phase_ff == stc_pkg::PH_FINE) begin
         upd_prev = 1'b1;
         if (tune_hit) begin
            dec_phase  = stc_pkg::PH_IDLE;
            dec_status = stc_pkg::ST_TUNED;
         end else begin
            upd_step   = 1'b1;
            dec_step   = fine_step;
            dec_status = (fine_step != '0) ? stc_pkg::ST_STEP : stc_pkg::ST_RESAMPLE;
         end
      end else if (jump_bad) begin
         dec_status = stc_pkg::ST_RESAMPLE;
      end else begin
         upd_prev = 1'b1;
         if (phase_ff == stc_pkg::PH_COARSE && (near_target || !slope_hi)) begin
            dec_phase = stc_pkg::PH_FINE;
            if (fine_step == '0) begin
               dec_status = stc_pkg::ST_RESAMPLE;
            end else begin
               upd_step   = 1'b1;
               dec_step   = fine_step;
               dec_status = stc_pkg::ST_STEP;
            end
         end else begin
            dec_phase  = stc_pkg::PH_COARSE;
            upd_step   = 1'b1;
            dec_status = stc_pkg::ST_STEP;
            if (!slope_hi) begin
               dec_step = reuse_step;
            end else if (secant_trivial) begin
               dec_step = SB'(1);
            end else begin
               use_div = 1'b1;
            end
         end
      end
   end

   assign res_step     = use_div ? secant_step : dec_step;
   assign sts.need_div = use_div;
   assign sts.div_done = (cnt_ff == stc_pkg::DIV_CNT_BITS'(stc_pkg::DIV_STEPS));

   // Restoring divider, one quotient bit a cycle
   assign product  = PB'(num_s[FB-1:0]) * PB'(last_step_ff);
   assign divisor  = delta_s[FB-1:0];
   assign trial    = {rem_ff, quo_ff[PB-1]};
   assign trial_ge = trial >= {1'b0, divisor};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = product;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in = trial_ge ? FB'(trial - {1'b0, divisor}) : trial[FB-1:0];
         quo_in = {quo_ff[PB-2:0], trial_ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // State update and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= stc_pkg::PH_IDLE;
         prev_freq_ff <= '0;
         last_step_ff <= '0;
         channel_ff   <= '0;
      end else if (cmd.commit) begin
         phase_ff <= dec_phase;
         if (upd_prev) begin
            prev_freq_ff <= freq_ff;
         end
         if (upd_step) begin
            last_step_ff <= res_step;
         end
         if (upd_chan) begin
            channel_ff <= sel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status_ff <= dec_status;
         out_step_ff   <= res_step;
         out_chan_ff   <= upd_chan ? sel_ff : channel_ff;
      end
   end

   assign rsp_status        = out_status_ff;
   assign rsp_step_count    = out_step_ff;
   assign rsp_motor_channel = out_chan_ff;

   // Division is only asked for on a probe or coarse reading
   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      sts.need_div |-> (phase_ff == stc_pkg::PH_PROBE || phase_ff == stc_pkg::PH_COARSE))
      else $error("division requested outside the coarse search");

   // A secant result is committed only once every quotient bit is in
   a_div_complete: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && sts.need_div) |-> sts.div_done)
      else $error("secant step committed before division finished");

   // The bit counter never runs past the dividend width
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= stc_pkg::DIV_CNT_BITS'(stc_pkg::DIV_STEPS))
      else $error("divider counter out of range");

endmodule

/* design/string_tuning_step_controller.sv */
// An accepted item is evaluated, then, when the coarse phase needs a secant step, divided
// by the 30-step bit-serial restoring divider, and its result is registered once the output
// register is free. A new item is accepted only after the previous result is committed.
// Reset (synchronous, active high) restores the register defaults, puts the tuner in
// the idle phase and clears the state and the result valid flag; no clearing pass.
module string_tuning_step_controller (
   input  logic        clock,
   input  logic        reset,
   stc_req_if.sink     req_if,
   stc_rsp_if.source   rsp_if,
   stc_csr_if.sink     csr_if
);

   stc_pkg::cmd_type       cmd;
   stc_pkg::dp_status_type sts;

   // Register writes are always taken
   assign csr_if.ready = 1'b1;

   stc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_if.valid && csr_if.ready),
      .csr_index         (csr_if.index),
      .csr_data          (csr_if.data),
      .req_mode          (req_if.mode),
      .req_string_sel    (req_if.string_sel),
      .req_measured_freq (req_if.measured_freq),
      .rsp_status        (rsp_if.status),
      .rsp_step_count    (rsp_if.step_count),
      .rsp_motor_channel (rsp_if.motor_channel)
   );

endmodule

/* tb/testbench.sv */
module testbench;
   import stc_pkg::*;

   // Longest stretch with no handshake on any channel before the run is abandoned
   localparam int QUIET_LIMIT   = 5000;
   // Cycles allowed for the block to drain after the last expected result
   localparam int SETTLE_CYCLES = 40;
   // Long receiver hold-off used to fill the block
   localparam int HOLD_OFF      = 400;

   typedef struct packed {
      logic                  mode;
      logic [CHAN_BITS-1:0]  string_sel;
      logic [FREQ_BITS-1:0]  measured_freq;
   } reading_type;

   typedef struct packed {
      status_type            status;
      logic [STEP_BITS-1:0]  step_count;
      logic [CHAN_BITS-1:0]  motor_channel;
   } tuner_answer_type;

   typedef enum {
      RX_OPEN,
      RX_COIN,
      RX_MOSTLY,
      RX_PERIODIC,
      RX_SPARSE
   } rx_pattern_type;

   logic clock;
   logic reset;

   stc_req_if req_ch ();
   stc_rsp_if rsp_ch ();
   stc_csr_if csr_ch ();

   string_tuning_step_controller dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Tuner copy: registers
   logic [FREQ_BITS-1:0]  cfg_target;
   logic [STEP_BITS-1:0]  cfg_first;
   logic [STEP_BITS-1:0]  cfg_max;
   logic [JUMP_BITS-1:0]  cfg_jump;

   // Tuner copy: state
   phase_type               tune_phase;
   logic [FREQ_BITS-1:0]    tune_prev_freq;
   logic [STEP_BITS-1:0]    tune_last_step;
   logic signed [FREQ_BITS:0] tune_last_delta;
   logic [CHAN_BITS-1:0]    tune_channel;

   tuner_answer_type expected_answers [$];
   tuner_answer_type last_answer;

   int  error_count   = 0;
   int  items_sent    = 0;
   int  results_seen  = 0;
   int  settings_used = 0;
   int  burst_left    = 0;
   int  status_count [4];
   bit  hold_request  = 1'b0;
   int  hold_cycles   = HOLD_OFF;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Fixed fine-phase step for a reading, 0 at or above target
   function automatic longint fine_step_for(longint freq, longint tgt);
      if (freq < tgt - FIVE_HZ) return FINE_STEP_XL;
      if (freq < tgt - ONE_HZ) return FINE_STEP_L;
      if (freq < tgt - HALF_HZ) return FINE_STEP_M;
      if (freq < tgt) return FINE_STEP_S;
      return 0;
   endfunction

   // Slope above 0.001 Hz per step, compared exactly
   function automatic bit slope_exceeds(longint delta, longint step);
      return delta * SLOPE_SCALE > longint'(ONE_HZ) * step;
   endfunction

   // Works out the answer to one reading and advances the tuner copy
   function automatic tuner_answer_type predict_answer(reading_type it);
      tuner_answer_type ans;
      longint freq, tgt, lim, delta, abs_delta, num, q, s;
      freq = longint'(it.measured_freq);
      tgt  = longint'(cfg_target);
      lim  = (cfg_max == '0) ? 1 : longint'(cfg_max);
      ans.status = ST_STEP;
      s = 0;
      if (it.mode == 1'b0) begin
         // start, or restart while busy
         tune_channel = it.string_sel;
         if (freq == 0) begin
            tune_phase = PH_IDLE;
            ans.status = ST_RESAMPLE;
         end else begin
            s = (cfg_first == '0) ? 1 : longint'(cfg_first);
            if (s > lim) s = lim;
            tune_prev_freq  = it.measured_freq;
            tune_last_step  = STEP_BITS'(s);
            tune_last_delta = '0;
            tune_phase      = PH_PROBE;
         end
      end else if (tune_phase == PH_IDLE) begin
         ans.status = ST_IGNORED;
      end else if (freq == 0) begin
         ans.status = ST_RESAMPLE;
      end else if (tune_phase == PH_FINE) begin
         tune_prev_freq = it.measured_freq;
         if (freq * TUNE_SCALE > tgt * TUNE_SCALE - TUNE_MARGIN) begin
            tune_phase = PH_IDLE;
            ans.status = ST_TUNED;
         end else begin
            s = fine_step_for(freq, tgt);
            tune_last_step = STEP_BITS'(s);
            if (s == 0) ans.status = ST_RESAMPLE;
         end
      end else begin
         // probe or coarse reading, jump window first
         delta     = freq - longint'(tune_prev_freq);
         abs_delta = (delta < 0) ? -delta : delta;
         if (abs_delta > longint'(cfg_jump)) begin
            ans.status = ST_RESAMPLE;
         end else begin
            tune_prev_freq  = it.measured_freq;
            tune_last_delta = delta[FREQ_BITS:0];
            if (tune_phase == PH_COARSE &&
                (freq >= tgt - TWO_HZ || !slope_exceeds(delta, tune_last_step))) begin
               tune_phase = PH_FINE;
               s = fine_step_for(freq, tgt);
               if (s == 0) ans.status = ST_RESAMPLE;
               else tune_last_step = STEP_BITS'(s);
            end else begin
               if (slope_exceeds(delta, tune_last_step)) begin
                  // secant toward target minus 1 Hz
                  num = tgt - ONE_HZ - freq;
                  if (num <= 0 || delta <= 0) begin
                     s = 1;
                  end else begin
                     q = (num * longint'(tune_last_step)) / delta;
                     s = (q < 1) ? 1 : ((q > lim) ? lim : q);
                  end
               end else begin
                  s = longint'(tune_last_step);
                  if (s > lim) s = lim;
                  if (s == 0) s = 1;
               end
               tune_phase     = PH_COARSE;
               tune_last_step = STEP_BITS'(s);
            end
         end
      end
      ans.step_count    = (ans.status == ST_STEP) ? STEP_BITS'(s) : '0;
      ans.motor_channel = tune_channel;
      return ans;
   endfunction

   function automatic logic [FREQ_BITS-1:0] to_reading(longint v);
      if (v < 0) return '0;
      if (v > (longint'(1) << FREQ_BITS) - 1) return '1;
      return FREQ_BITS'(v);
   endfunction

   // Register value with random junk above its width
   function automatic logic [CSR_DATA_BITS-1:0] pad_high_bits(longint value, int width);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = CSR_DATA_BITS'($urandom());
      return (junk << width) | CSR_DATA_BITS'(value);
   endfunction

   // Offers one reading in bursts with random gaps; records its expected answer
   task automatic send_reading(input logic mode, input logic [CHAN_BITS-1:0] sel,
                               input logic [FREQ_BITS-1:0] freq);
      reading_type it;
      int gap;
      it.mode          = mode;
      it.string_sel    = sel;
      it.measured_freq = freq;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= mode;
      req_ch.string_sel    <= sel;
      req_ch.measured_freq <= freq;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      last_answer = predict_answer(it);
      expected_answers.push_back(last_answer);
      if (last_answer.status != ST_IGNORED) items_sent++;
      burst_left--;
   endtask

   // Drops valid, waits for every answer and then lets the block settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers, only ever called with the block idle
   task automatic write_settings(input logic [CSR_DATA_BITS-1:0] tgt, first, maxs, jump);
      reg_index_type order [4];
      logic [CSR_DATA_BITS-1:0] value [4];
      int i;
      order = '{REG_TARGET_FREQ, REG_FIRST_STEP, REG_MAX_STEP, REG_JUMP_WINDOW};
      value = '{tgt, first, maxs, jump};
      for (i = 0; i < 4; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= order[i];
         csr_ch.data  <= value[i];
         @(posedge clock);
         while (csr_ch.ready !== 1'b1) @(posedge clock);
         case (order[i])
            REG_TARGET_FREQ: cfg_target = value[i][FREQ_BITS-1:0];
            REG_FIRST_STEP:  cfg_first  = value[i][STEP_BITS-1:0];
            REG_MAX_STEP:    cfg_max    = value[i][STEP_BITS-1:0];
            REG_JUMP_WINDOW: cfg_jump   = value[i][JUMP_BITS-1:0];
            default: ;
         endcase
      end
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // Idle readings, starts, zero readings, jump rejects and restart mid-probe
   task automatic test_idle_and_start();
      send_reading(1'b1, 3'd5, 20'd1000);
      send_reading(1'b0, 3'd7, 20'd0);
      send_reading(1'b1, 3'd7, 20'd20000);
      send_reading(1'b0, 3'd3, 20'd20000);
      send_reading(1'b1, 3'd3, 20'd0);
      send_reading(1'b1, 3'd3, 20'd30000);
      send_reading(1'b0, 3'd4, 20'd5000);
      send_reading(1'b1, 3'd2, 20'd5100);
   endtask

   // Probe, coarse secant, fine ladder, in tune; fine entry above target
   task automatic test_phase_walk();
      send_reading(1'b0, 3'd3, 20'd20000);
      send_reading(1'b1, 3'd3, 20'd21000);
      send_reading(1'b1, 3'd3, 20'd22000);
      send_reading(1'b1, 3'd3, 20'd22000);
      send_reading(1'b1, 3'd3, 20'd27000);
      send_reading(1'b1, 3'd3, 20'd28000);
      send_reading(1'b1, 3'd3, 20'd28100);
      send_reading(1'b1, 3'd3, 20'd28140);
      send_reading(1'b0, 3'd0, '1);
      send_reading(1'b1, 3'd0, '1);
      send_reading(1'b1, 3'd0, '1);
      send_reading(1'b1, 3'd0, '1);
      send_reading(1'b0, 3'd6, 20'd27700);
      send_reading(1'b1, 3'd6, 20'd27800);
      send_reading(1'b1, 3'd6, 20'd27700);
   endtask

   // Zero step registers, zero window, widest values, probe clamped by max_step
   task automatic test_register_extremes();
      wait_idle();
      write_settings(20'h00000, 20'hFFC00, 20'hFFC00, 20'hF0000);
      send_reading(1'b0, 3'd1, 20'd5);
      send_reading(1'b1, 3'd1, 20'd6);
      send_reading(1'b1, 3'd1, 20'd5);
      send_reading(1'b1, 3'd1, 20'd5);
      send_reading(1'b1, 3'd1, 20'd5);
      wait_idle();
      write_settings(20'hFFFFF, 20'd1023, 20'd1023, 20'd65535);
      send_reading(1'b0, 3'd7, 20'd1);
      send_reading(1'b1, 3'd7, 20'd65536);
      send_reading(1'b1, 3'd7, 20'd131072);
      wait_idle();
      write_settings(CSR_DATA_BITS'(TARGET_RESET), 20'd900, 20'd300,
                     CSR_DATA_BITS'(JUMP_RESET));
      send_reading(1'b0, 3'd2, 20'd20000);
   endtask

   // Receiver holds off for a long stretch while readings keep coming
   task automatic test_back_pressure();
      int i;
      wait_idle();
      write_settings(CSR_DATA_BITS'(TARGET_RESET), CSR_DATA_BITS'(FIRST_RESET),
                     CSR_DATA_BITS'(MAX_RESET), CSR_DATA_BITS'(JUMP_RESET));
      hold_cycles  = HOLD_OFF;
      hold_request = 1'b1;
      burst_left   = 40;
      send_reading(1'b0, 3'd5, 20'd20000);
      for (i = 1; i < 16; i++) send_reading(1'b1, 3'd5, to_reading(20000 + i * 600));
      wait_idle();
   endtask

   // One tuning attempt against a simulated string with random response
   task automatic run_session(input int max_items);
      longint truth, gain, tgt, offset;
      int n, pick;
      tgt = longint'(cfg_target);
      case ($urandom_range(0, 3))
         0: truth = tgt - longint'($urandom_range(0, 600));
         1: truth = tgt - longint'($urandom_range(0, 8000));
         2: truth = tgt - longint'($urandom_range(0, int'(tgt / 2)));
         default: truth = tgt + longint'($urandom_range(0, 2000));
      endcase
      if (truth < 1) truth = 1;
      gain = longint'($urandom_range(0, 96));
      send_reading(1'b0, CHAN_BITS'($urandom_range(0, 7)),
                   to_reading(truth + longint'($urandom_range(0, 16)) - 8));
      n = 1;
      while (n < max_items && last_answer.status != ST_TUNED) begin
         // string follows the commanded step, gain in 1/16 unit per step
         if (last_answer.status == ST_STEP)
            truth = truth + (longint'(last_answer.step_count) * gain) / 16;
         pick = $urandom_range(0, 99);
         if (tune_phase == PH_IDLE || pick < 3) begin
            send_reading(1'b0, CHAN_BITS'($urandom_range(0, 7)), to_reading(truth));
         end else if (pick < 7) begin
            send_reading(1'b1, CHAN_BITS'($urandom_range(0, 7)), '0);
         end else if (pick < 11) begin
            offset = longint'(cfg_jump) + longint'($urandom_range(1, 4000));
            if ($urandom_range(0, 1) == 1) offset = -offset;
            send_reading(1'b1, CHAN_BITS'($urandom_range(0, 7)), to_reading(truth + offset));
         end else begin
            send_reading(1'b1, CHAN_BITS'($urandom_range(0, 7)),
                         to_reading(truth + longint'($urandom_range(0, 16)) - 8));
         end
         n++;
      end
   endtask

   // Random sessions and noise over a series of register settings
   task automatic test_random_tuning();
      longint tgt, fs, ms, jw;
      int k, quota, stop_at, j;
      for (k = 0; k < 10; k++) begin
         tgt = ($urandom_range(0, 1) == 1) ? longint'($urandom_range(10000, 200000))
                                           : longint'($urandom_range(1000, 1048575));
         fs  = longint'($urandom_range(1, 1023));
         ms  = longint'($urandom_range(1, 1023));
         jw  = longint'($urandom_range(256, 65535));
         quota = 160;
         case (k)
            0: begin
               tgt = TARGET_RESET;
               fs  = FIRST_RESET;
               ms  = MAX_RESET;
               jw  = JUMP_RESET;
               quota = 150;
            end
            7: begin
               fs = 1;
               ms = 1;
               jw = 65535;
               quota = 100;
            end
            8: begin
               // zero window: every probe or coarse change is rejected
               fs = 1023;
               ms = 1023;
               jw = 0;
               quota = 40;
            end
            9: begin
               tgt = 1048575;
               fs  = 1023;
               ms  = 1023;
               jw  = 65535;
               quota = 150;
            end
            default: ;
         endcase
         wait_idle();
         write_settings(pad_high_bits(tgt, FREQ_BITS), pad_high_bits(fs, STEP_BITS),
                        pad_high_bits(ms, STEP_BITS), pad_high_bits(jw, JUMP_BITS));
         stop_at = items_sent + quota;
         while (items_sent < stop_at) begin
            run_session(30);
            for (j = $urandom_range(0, 2); j > 0; j--)
               send_reading(1'($urandom_range(0, 1)), CHAN_BITS'($urandom_range(0, 7)),
                            FREQ_BITS'($urandom()));
         end
      end
   endtask

   // Result receiver: changing stall patterns plus the requested hold-off
   initial begin : result_receiver
      rx_pattern_type pattern;
      int left, i;
      rsp_ch.ready <= 1'b0;
      pattern = RX_OPEN;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (i = 1; i < hold_cycles; i++) @(posedge clock);
         end else begin
            if (left == 0) begin
               pattern = rx_pattern_type'($urandom_range(0, 4));
               left = $urandom_range(32, 400);
            end
            left--;
            case (pattern)
               RX_OPEN:     rsp_ch.ready <= 1'b1;
               RX_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
               RX_MOSTLY:   rsp_ch.ready <= ($urandom_range(0, 9) != 0);
               RX_PERIODIC: rsp_ch.ready <= (left % 4 == 0);
               default:     rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Result checker: each answer against the oldest expectation
   always @(posedge clock) begin : answer_check
      tuner_answer_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         results_seen++;
         status_count[rsp_ch.status]++;
         if (expected_answers.size() == 0) begin
            $display("%0t: answer with none expected, status %0d step %0d channel %0d",
                     $time, rsp_ch.status, rsp_ch.step_count, rsp_ch.motor_channel);
            error_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0d, actual %0d",
                        $time, want.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.step_count !== want.step_count) begin
               $display("%0t: step_count expected %0d, actual %0d",
                        $time, want.step_count, rsp_ch.step_count);
               error_count++;
            end
            if (rsp_ch.motor_channel !== want.motor_channel) begin
               $display("%0t: motor_channel expected %0d, actual %0d",
                        $time, want.motor_channel, rsp_ch.motor_channel);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake anywhere
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
             (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: nothing moved for %0d cycles, %0d answers outstanding",
               $time, QUIET_LIMIT, expected_answers.size());
      $display("** string_tuning_step_controller: FAILED **");
      $finish;
   end

   initial begin : run_tests
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.mode          <= 1'b0;
      req_ch.string_sel    <= '0;
      req_ch.measured_freq <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= REG_TARGET_FREQ;
      csr_ch.data          <= '0;
      cfg_target      = TARGET_RESET;
      cfg_first       = FIRST_RESET;
      cfg_max         = MAX_RESET;
      cfg_jump        = JUMP_RESET;
      tune_phase      = PH_IDLE;
      tune_prev_freq  = '0;
      tune_last_step  = '0;
      tune_last_delta = '0;
      tune_channel    = '0;
      status_count    = '{default: 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_start();
      test_phase_walk();
      test_register_extremes();
      test_back_pressure();
      test_random_tuning();
      wait_idle();

      $display("Checked %0d answers to %0d counted readings over %0d register settings",
               results_seen, items_sent, settings_used);
      $display("Answers seen: %0d steps, %0d resamples, %0d in tune, %0d ignored",
               status_count[ST_STEP], status_count[ST_RESAMPLE],
               status_count[ST_TUNED], status_count[ST_IGNORED]);
      if (error_count == 0)
         $display("** string_tuning_step_controller: PASSED **");
      else
         $display("** string_tuning_step_controller: FAILED **");
      $finish;
   end

endmodule
